>>> src/lora_at_pkg.sv
// Shared constants, widths and helper functions for the LoRa airtime calculator.
// No dependencies; every other file imports this package.

package lora_at_pkg;

    localparam int LEN_W      = 8;
    localparam int SF_W       = 4;
    localparam int BW_W       = 20;
    localparam int CR_W       = 4;
    localparam int AIR_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = BW_W;

    localparam int MAX_PAYLOAD_DEF = 255;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CR = 2'd2;

    localparam logic [SF_W-1:0] SF_RESET = 4'd7;
    localparam logic [BW_W-1:0] BW_RESET = 20'd125000;
    localparam logic [CR_W-1:0] CR_RESET = 4'd5;

    localparam logic [SF_W-1:0] SF_MIN   = 4'd5;
    localparam logic [SF_W-1:0] SF_MAX   = 4'd12;
    localparam logic [SF_W-1:0] SF_LDRO  = 4'd11;
    localparam logic [CR_W-1:0] CR_MIN   = 4'd5;
    localparam logic [CR_W-1:0] CR_MAX   = 4'd8;
    localparam logic [BW_W-1:0] BW_LDRO  = 20'd125000;

    localparam int TSYM_W = 32;                 // symbol time in us
    localparam int PRE_W  = TSYM_W + 4;         // 49/4 of a symbol time
    localparam int SYM_W  = 11;                 // payload + header symbols
    localparam int US_W   = TSYM_W + SYM_W;     // symbols * tsym
    localparam int Y_W    = 40;                 // us / 8, padded to whole bytes
    localparam int NDIG   = Y_W / 8;            // base-256 digits of the /125 stage

    localparam logic [TSYM_W-1:0] US_PER_S = 32'd1000000;
    localparam logic [US_W:0]     ROUND_US = 44'd999;

    // floor(x / 125) = (x * DIV125_RECIP) >> DIV125_SH for x < 2^15
    localparam logic [15:0] DIV125_RECIP = 16'd33555;
    localparam int          DIV125_SH    = 22;
    localparam int          RECIP_SH     = 16;

    // ceil(2^16 / k) for the block divisor k = sf - 2*ldro
    function automatic logic [13:0] recip_k(input logic [SF_W-1:0] k);
        logic [13:0] r;
        case (k)
            4'd5:    r = 14'd13108;
            4'd6:    r = 14'd10923;
            4'd7:    r = 14'd9363;
            4'd8:    r = 14'd8192;
            4'd9:    r = 14'd7282;
            4'd10:   r = 14'd6554;
            4'd11:   r = 14'd5958;
            4'd12:   r = 14'd5462;
            default: r = 14'd0;
        endcase
        return r;
    endfunction

endpackage

>>> src/lora_at_req_if.sv
// Input channel: one payload length word per handshake.
// Depends on lora_at_pkg for the field width.

interface lora_at_req_if import lora_at_pkg::*;;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] payload_length;

    modport source (output valid, output payload_length, input ready);
    modport sink   (input valid, input payload_length, output ready);
endinterface

>>> src/lora_at_rsp_if.sv
// Result channel: airtime in ms and the configuration error flag.
// Depends on lora_at_pkg for the field widths.

interface lora_at_rsp_if import lora_at_pkg::*;;
    logic             valid;
    logic             ready;
    logic [AIR_W-1:0] airtime_ms;
    logic             config_error;

    modport source (output valid, output airtime_ms, output config_error, input ready);
    modport sink   (input valid, input airtime_ms, input config_error, output ready);
endinterface

>>> src/lora_airtime_calculator.sv
// LoRa time-on-air calculator: payload length in, airtime in ms (rounded up) out.
// Depends on lora_at_pkg, lora_at_req_if and lora_at_rsp_if.

// The block takes one payload length word per cycle while the divider is idle and
// the result side accepts; the eleven stage pipeline holds one word per stage and
// stalls as a whole when the result side holds off. Symbol time and preamble time
// depend only on spreading factor and bandwidth, so they are worked out once by a
// bit-serial divider: after reset and after every configuration write the input
// holds ready low through one load, 32 divide steps and one preamble step.
// Configuration errors give airtime 0 with config_error set.

module lora_airtime_calculator import lora_at_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    lora_at_req_if.sink           req,
    lora_at_rsp_if.source         rsp
);

    localparam int NST = 6 + NDIG;              // pipeline stages incl. output
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_PRE  = 4'b0100,
        ST_IDLE = 4'b1000
    } div_state_t;

    // configuration
    logic [SF_W-1:0] sf_reg;
    logic [BW_W-1:0] bw_reg;
    logic [CR_W-1:0] cr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sf_reg <= SF_RESET;
            bw_reg <= BW_RESET;
            cr_reg <= CR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SF:  sf_reg <= cfg_data[SF_W-1:0];
                CFG_BW:  bw_reg <= cfg_data[BW_W-1:0];
                CFG_CR:  cr_reg <= cfg_data[CR_W-1:0];
                default: ;
            endcase
        end
    end

    logic            ldro;
    logic            cfg_err;
    logic [SF_W-1:0] blk_div;

    assign ldro    = (sf_reg >= SF_LDRO) && (bw_reg <= BW_LDRO);
    assign cfg_err = (sf_reg < SF_MIN) || (sf_reg > SF_MAX) || (bw_reg == '0)
                   || (cr_reg < CR_MIN) || (cr_reg > CR_MAX);
    assign blk_div = ldro ? sf_reg - SF_W'(2) : sf_reg;

    // symbol time divider: quotient bits shift into the dividend register
    div_state_t        state_reg, state_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [TSYM_W-1:0] quo_reg, quo_next;
    logic [BW_W-1:0]   rem_reg, rem_next;
    logic [PRE_W-1:0]  pre_reg, pre_next;
    logic [BW_W:0]     rem_shift;
    logic [PRE_W+1:0]  pre_sum;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        pre_next   = pre_reg;
        rem_shift  = {rem_reg, quo_reg[TSYM_W-1]};
        pre_sum    = ((PRE_W+2)'(quo_reg) << 5) + ((PRE_W+2)'(quo_reg) << 4)
                   + (PRE_W+2)'(quo_reg);
        case (state_reg)
            ST_LOAD:
            begin
                quo_next   = US_PER_S << sf_reg;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (rem_shift >= {1'b0, bw_reg})
                begin
                    rem_next = BW_W'(rem_shift - {1'b0, bw_reg});
                    quo_next = {quo_reg[TSYM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[BW_W-1:0];
                    quo_next = {quo_reg[TSYM_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    state_next = ST_PRE;
            end
            ST_PRE:
            begin
                pre_next   = pre_sum[PRE_W+1:2];
                state_next = ST_IDLE;
            end
            ST_IDLE: ;
            default: state_next = ST_LOAD;
        endcase
        if (cfg_write)
            state_next = ST_LOAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        pre_reg <= pre_next;
    end

    // item pipeline
    logic [NST-1:0] v_reg;
    logic           en;
    logic           accept;

    assign en        = !v_reg[NST-1] || rsp.ready;
    assign req.ready = en && (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NST-2:0], accept};
    end

    // stage 1: blocks = ceil((2*len - sf + 11) / k), numerator taken as x = t - 1 - 2*ldro
    logic [LEN_W-1:0] len_sat;
    logic [10:0]      t1;
    logic [9:0]       x1_reg;
    logic             pos1_reg;

    assign len_sat = (req.payload_length > MAX_LEN) ? MAX_LEN : req.payload_length;
    assign t1      = {2'b0, len_sat, 1'b0} + 11'd11;

    // stage 2: reciprocal multiply
    logic [23:0] prod2;
    logic [6:0]  blk2_reg;

    assign prod2 = 24'(x1_reg) * 24'(recip_k(blk_div));

    // stages 3 to 5: symbols, microseconds, rounding and /8
    logic [SYM_W-1:0] syms3_reg;
    logic [US_W-1:0]  us4_reg;
    logic [US_W:0]    sum5;
    logic [Y_W-1:0]   y5_reg;

    assign sum5 = (US_W+1)'(us4_reg) + (US_W+1)'(pre_reg) + ROUND_US;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg    <= 10'(t1 - 11'd1 - (ldro ? 11'd2 : 11'd0));
            pos1_reg  <= t1 > {7'b0, sf_reg};
            blk2_reg  <= pos1_reg ? prod2[RECIP_SH+6:RECIP_SH] : 7'd0;
            syms3_reg <= SYM_W'(8) + SYM_W'(blk2_reg) * SYM_W'(cr_reg);
            us4_reg   <= US_W'(syms3_reg) * US_W'(quo_reg);
            y5_reg    <= sum5[Y_W+2:3];
        end
    end

    // stages 6 onward: long division by 125, one byte per stage
    logic [6:0]     dr_reg [NDIG];
    logic [Y_W-1:0] dy_reg [NDIG];
    logic [6:0]     dr_in  [NDIG];
    logic [Y_W-1:0] dy_in  [NDIG];
    logic [6:0]     dr_next [NDIG];
    logic [Y_W-1:0] dy_next [NDIG];
    logic [14:0]    dx     [NDIG];
    logic [30:0]    dm     [NDIG];
    logic [7:0]     dq     [NDIG];

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (i == 0)
            begin
                dr_in[i] = '0;
                dy_in[i] = y5_reg;
            end
            else
            begin
                dr_in[i] = dr_reg[i-1];
                dy_in[i] = dy_reg[i-1];
            end
            dx[i]      = {dr_in[i], dy_in[i][Y_W-1:Y_W-8]};
            dm[i]      = 31'(dx[i]) * 31'(DIV125_RECIP);
            dq[i]      = dm[i][DIV125_SH+7:DIV125_SH];
            dr_next[i] = 7'(dx[i] - 15'({dq[i], 7'b0}) + 15'({dq[i], 2'b0}) - 15'(dq[i]));
            dy_next[i] = {dy_in[i][Y_W-9:0], dq[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NDIG; i++)
            begin
                dr_reg[i] <= dr_next[i];
                dy_reg[i] <= dy_next[i];
            end
        end
    end

    // output register
    logic [AIR_W-1:0] air_reg;
    logic             err_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            air_reg <= cfg_err ? '0 : dy_reg[NDIG-1][AIR_W-1:0];
            err_reg <= cfg_err;
        end
    end

    assign rsp.valid        = v_reg[NST-1];
    assign rsp.airtime_ms   = air_reg;
    assign rsp.config_error = err_reg;

`ifndef NO_ASSERTIONS
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !req.ready)
        else $error("input accepted while symbol time is recomputed");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.config_error |-> rsp.airtime_ms == '0)
        else $error("nonzero airtime on a configuration error");

    a_idle_after_pre: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) && ($past(state_reg) != ST_IDLE)
        |-> $past(state_reg) == ST_PRE)
        else $error("divider went idle without the preamble step");
`endif

endmodule
